FILE: rtl/pds_pkg.sv
// shared types and constants for the particle depth sorter
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned DIST_W  = 34;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dsq;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/pds_dist.sv
// two-stage squared distance pipeline from particle to camera
`timescale 1ns / 1ps
`default_nettype none

module pds_dist (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_keep_i,
  input  wire logic                         in_last_i,
  input  wire logic [pds_pkg::IDX_W-1:0]    in_idx_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] pos_x_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] pos_y_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] pos_z_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] cam_x_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] cam_y_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0] cam_z_i,
  output pds_pkg::entry_t                   ent_o,
  output logic                              last_o
);
  import pds_pkg::*;

  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W-1:0] ax, ay, az;
  logic [SQ_W-1:0] sqx_d, sqy_d, sqz_d;
  logic [SQ_W-1:0] sqx_q, sqy_q, sqz_q;
  logic            v1_q, keep1_q, last1_q;
  logic [IDX_W-1:0] idx1_q;
  logic [DIST_W-1:0] sum_d, sum_q;
  logic            keep2_q, last2_q;
  logic [IDX_W-1:0] idx2_q;

  always_comb begin
    dx = {pos_x_i[COORD_W-1], pos_x_i} - {cam_x_i[COORD_W-1], cam_x_i};
    dy = {pos_y_i[COORD_W-1], pos_y_i} - {cam_y_i[COORD_W-1], cam_y_i};
    dz = {pos_z_i[COORD_W-1], pos_z_i} - {cam_z_i[COORD_W-1], cam_z_i};
    ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    az = dz[COORD_W] ? COORD_W'(-dz) : dz[COORD_W-1:0];
    sqx_d = SQ_W'(ax) * SQ_W'(ax);
    sqy_d = SQ_W'(ay) * SQ_W'(ay);
    sqz_d = SQ_W'(az) * SQ_W'(az);
    sum_d = DIST_W'(sqx_q) + DIST_W'(sqy_q) + DIST_W'(sqz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      keep1_q <= 1'b0;
      last1_q <= 1'b0;
      keep2_q <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v1_q    <= in_valid_i;
      keep1_q <= in_valid_i & in_keep_i;
      last1_q <= in_valid_i & in_last_i;
      keep2_q <= v1_q & keep1_q;
      last2_q <= v1_q & last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    sqz_q  <= sqz_d;
    idx1_q <= in_idx_i;
    sum_q  <= sum_d;
    idx2_q <= idx1_q;
  end

  assign ent_o.valid = keep2_q;
  assign ent_o.dsq   = sum_q;
  assign ent_o.idx   = idx2_q;
  assign last_o      = last2_q;

endmodule

`default_nettype wire

FILE: rtl/pds_cell.sv
// one slot of the insertion chain, kept sorted farthest first
`timescale 1ns / 1ps
`default_nettype none

module pds_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  pds_pkg::cell_ctrl_t ctrl_i,
  input  pds_pkg::entry_t    new_i,
  input  pds_pkg::entry_t    left_i,
  input  pds_pkg::entry_t    right_i,
  input  wire logic          gt_left_i,
  output logic               gt_o,
  output pds_pkg::entry_t    q_o
);
  import pds_pkg::*;

  logic valid_q, valid_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic load;

  // new word goes ahead of this slot when the slot is empty or the new word is strictly farther
  assign gt_o = !valid_q || (dist_q < new_i.dsq);

  always_comb begin
    valid_d = valid_q;
    dist_d  = dist_q;
    idx_d   = idx_q;
    load    = 1'b0;
    if (ctrl_i.drain) begin
      load    = 1'b1;
      valid_d = right_i.valid;
      dist_d  = right_i.dsq;
      idx_d   = right_i.idx;
    end else if (ctrl_i.insert && gt_o) begin
      load = 1'b1;
      if (gt_left_i) begin
        valid_d = left_i.valid;
        dist_d  = left_i.dsq;
        idx_d   = left_i.idx;
      end else begin
        valid_d = 1'b1;
        dist_d  = new_i.dsq;
        idx_d   = new_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dist_q <= dist_d;
      idx_q  <= idx_d;
    end
  end

  assign q_o.valid = valid_q;
  assign q_o.dsq   = dist_q;
  assign q_o.idx   = idx_q;

endmodule

`default_nettype wire

FILE: rtl/particle_depth_sorter_top.sv
// particle depth sorter: distance pipeline feeding a sorted insertion chain
// the first result appears after the last particle has passed the distance pipeline and the wait state
// throughput: one particle per cycle while collecting, then one result per cycle
// busy stays high from the last particle until the final result
// the receiver cannot stall; results leave the head of the chain as it shifts
// reset clears counters, valid bits and camera registers; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module particle_depth_sorter_top #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [pds_pkg::COORD_W-1:0]         cfg_data_i,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [pds_pkg::COORD_W-1:0]  pos_x_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0]  pos_y_i,
  input  wire logic signed [pds_pkg::COORD_W-1:0]  pos_z_i,
  input  wire logic                                active_i,
  input  wire logic                                last_particle_i,
  output logic                                     result_valid_o,
  output logic [pds_pkg::IDX_W-1:0]                particle_index_o,
  output logic [pds_pkg::DIST_W-1:0]               distance_squared_o,
  output logic                                     last_result_o,
  output logic                                     none_active_o,
  output logic                                     overflow_o
);
  import pds_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic signed [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [CNT_W-1:0] arrival_q, arrival_d;
  logic ovf_seen_q, ovf_seen_d;
  logic run_ovf_q, run_ovf_d;
  logic accept, drop, ovf_now;

  entry_t     ent;
  logic       dist_last;
  cell_ctrl_t ctrl;
  entry_t     cell_q   [MAX_PARTICLES];
  logic       cell_gt  [MAX_PARTICLES];

  assign accept  = start && !busy;
  assign drop    = arrival_q >= CNT_W'(MAX_PARTICLES);
  assign ovf_now = ovf_seen_q | drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAMERA_X: cam_x_q <= cfg_data_i;
        REG_CAMERA_Y: cam_y_q <= cfg_data_i;
        REG_CAMERA_Z: cam_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pds_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_keep_i  (active_i && !drop),
    .in_last_i  (last_particle_i),
    .in_idx_i   (IDX_W'(arrival_q)),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .cam_x_i    (cam_x_q),
    .cam_y_i    (cam_y_q),
    .cam_z_i    (cam_z_q),
    .ent_o      (ent),
    .last_o     (dist_last)
  );

  assign ctrl.insert = ent.valid;
  assign ctrl.drain  = (state_q == ST_EMIT);

  for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   gt_left;
    if (k == 0) begin : g_head
      assign left_ent = '0;
      assign gt_left  = 1'b0;
    end else begin : g_body
      assign left_ent = cell_q[k-1];
      assign gt_left  = cell_gt[k-1];
    end
    if (k == MAX_PARTICLES - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_q[k+1];
    end
    pds_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (ent),
      .left_i    (left_ent),
      .right_i   (right_ent),
      .gt_left_i (gt_left),
      .gt_o      (cell_gt[k]),
      .q_o       (cell_q[k])
    );
  end

  always_comb begin
    state_d    = state_q;
    arrival_d  = arrival_q;
    ovf_seen_d = ovf_seen_q;
    run_ovf_d  = run_ovf_q;
    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (!drop) begin
            arrival_d = arrival_q + 1'b1;
          end
          ovf_seen_d = ovf_now;
          if (last_particle_i) begin
            run_ovf_d  = ovf_now;
            arrival_d  = '0;
            ovf_seen_d = 1'b0;
            state_d    = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (dist_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_result_o) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      arrival_q  <= '0;
      ovf_seen_q <= 1'b0;
      run_ovf_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      arrival_q  <= arrival_d;
      ovf_seen_q <= ovf_seen_d;
      run_ovf_q  <= run_ovf_d;
    end
  end

  assign busy               = (state_q != ST_RUN);
  assign result_valid_o     = (state_q == ST_EMIT);
  assign none_active_o      = result_valid_o && !cell_q[0].valid;
  assign last_result_o      = result_valid_o && (!cell_q[0].valid || !cell_q[1].valid);
  assign overflow_o         = last_result_o && run_ovf_q;
  assign particle_index_o   = cell_q[0].valid ? cell_q[0].idx : '0;
  assign distance_squared_o = cell_q[0].valid ? cell_q[0].dsq : '0;

  a_final_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |=> !busy)
    else $error("run did not end after final result");

  a_empty_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    none_active_o |-> (last_result_o && particle_index_o == '0))
    else $error("empty result not marked final");

  a_results_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |=> result_valid_o)
    else $error("gap in result sequence");

  a_no_insert_while_draining : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.drain |-> !ctrl.insert)
    else $error("insert during drain");

endmodule

`default_nettype wire
